>>> rtl/core/sclp_pkg.sv
package sclp_pkg;

  // Command codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_LOAD    = 2'd1,
    OP_REQUEST = 2'd2,
    OP_BEGIN   = 2'd3
  } op_e;

  // One command as it arrives on the input channel.
  typedef struct packed {
    op_e         opcode;
    logic [31:0] frame_count;
    logic        bounds_present;
    logic [63:0] new_loop_start;
    logic [63:0] new_loop_end;
  } in_t;

  // One report as it leaves on the output channel.
  typedef struct packed {
    logic [63:0] sample_total;
    logic [63:0] loop_position;
    logic [63:0] loop_iteration;
    logic        looping;
  } out_t;

  // Work handed from the front part to the divider side.
  typedef struct packed {
    logic [63:0] total;
    logic [63:0] start;
    logic [63:0] off;
    logic [63:0] len;
    logic        map_en;
  } job_t;

  // Divider side states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } bk_state_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage

>>> rtl/core/sclp_front.sv
module sclp_front
  import sclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic push_o,
  output job_t push_data_o,
  input  logic full_i
);

  logic [63:0] cnt_q, cnt_d;
  logic [63:0] act_start_q, act_start_d;
  logic [63:0] act_end_q, act_end_d;
  logic        act_valid_q, act_valid_d;
  logic [63:0] pnd_start_q, pnd_start_d;
  logic [63:0] pnd_end_q, pnd_end_d;
  logic        pnd_valid_q, pnd_valid_d;
  logic        busy_q, busy_d;
  logic        accept;

  // One command at a time: the state is updated on the transfer and the
  // job is classified from the updated state in the following cycle.
  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = busy_q && !full_i;

  // Apply the command to the counter and the two copies of the bounds.
  always_comb begin
    cnt_d       = cnt_q;
    act_start_d = act_start_q;
    act_end_d   = act_end_q;
    act_valid_d = act_valid_q;
    pnd_start_d = pnd_start_q;
    pnd_end_d   = pnd_end_q;
    pnd_valid_d = pnd_valid_q;
    busy_d      = busy_q;
    if (push_o) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      unique case (in_data_i.opcode)
        OP_ADVANCE: begin
          cnt_d = cnt_q + {32'd0, in_data_i.frame_count};
        end
        OP_LOAD: begin
          if (in_data_i.bounds_present) begin
            act_start_d = in_data_i.new_loop_start;
            act_end_d   = in_data_i.new_loop_end;
          end
          act_valid_d = in_data_i.bounds_present;
        end
        OP_REQUEST: begin
          if (in_data_i.bounds_present) begin
            pnd_start_d = in_data_i.new_loop_start;
            pnd_end_d   = in_data_i.new_loop_end;
          end
          pnd_valid_d = in_data_i.bounds_present;
        end
        OP_BEGIN: begin
          if (pnd_valid_q) begin
            act_start_d = pnd_start_q;
            act_end_d   = pnd_end_q;
            act_valid_d = 1'b1;
            pnd_valid_d = 1'b0;
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      act_start_q <= '0;
      act_end_q   <= '0;
      act_valid_q <= 1'b0;
      pnd_start_q <= '0;
      pnd_end_q   <= '0;
      pnd_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      act_start_q <= act_start_d;
      act_end_q   <= act_end_d;
      act_valid_q <= act_valid_d;
      pnd_start_q <= pnd_start_d;
      pnd_end_q   <= pnd_end_d;
      pnd_valid_q <= pnd_valid_d;
      busy_q      <= busy_d;
    end
  end

  // Classify: the loop maps only with valid, non-empty bounds already reached.
  always_comb begin
    push_data_o.total  = cnt_q;
    push_data_o.start  = act_start_q;
    push_data_o.off    = cnt_q - act_start_q;
    push_data_o.len    = act_end_q - act_start_q;
    push_data_o.map_en = act_valid_q && (act_end_q > act_start_q) &&
                         (cnt_q >= act_start_q);
  end

endmodule

>>> rtl/core/sclp_queue.sv
module sclp_queue
  import sclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage is payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sclp_back.sv
module sclp_back
  import sclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t pop_data_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  bk_state_e   state_q, state_d;
  logic [63:0] total_q, total_d;
  logic [63:0] start_q, start_d;
  logic [63:0] len_q, len_d;
  logic        map_q, map_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [5:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;
  logic [64:0] trial;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Trial subtraction of one restoring division step.
  assign trial = {rem_q, quo_q[63]} - {1'b0, len_q};

  // Next state: take a job, divide one quotient bit a cycle if it maps, then report.
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    start_d     = start_q;
    len_d       = len_q;
    map_d       = map_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          total_d = pop_data_i.total;
          start_d = pop_data_i.start;
          len_d   = pop_data_i.len;
          map_d   = pop_data_i.map_en;
          rem_d   = '0;
          quo_d   = pop_data_i.off;
          step_d  = '0;
          state_d = pop_data_i.map_en ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        if (!trial[64]) begin
          rem_d = trial[63:0];
        end else begin
          rem_d = {rem_q[62:0], quo_q[63]};
        end
        quo_d  = {quo_q[62:0], !trial[64]};
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.sample_total   = total_q;
          out_d.loop_position  = map_q ? (start_q + rem_q) : total_q;
          out_d.loop_iteration = map_q ? quo_q : '0;
          out_d.looping        = map_q;
          state_d              = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // Datapath registers carry payload only.
  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    start_q <= start_d;
    len_q   <= len_d;
    map_q   <= map_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    out_q   <= out_d;
  end

endmodule

>>> rtl/core/sample_clock_loop_position_top.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_ready_o | in_data_i  (in_t)
// output  | out       | out_valid_o/ out_ready_i| out_data_o (out_t)
//
// One command is taken at a time; the next transfer is accepted only after
// the previous job has been pushed into the job queue, once it has room.
// A mapped report is computed by the 64-step restoring divider; an
// unmapped report skips the divider.
// Reset clears the counter, both loop copies and all handshake state.
// A stalled output holds its report while the queue takes further jobs.
module sample_clock_loop_position_top
  import sclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  job_t push_data, pop_data;
  logic push, full, pop, empty;

  // Command decode and state update.
  sclp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Short job queue between the two sides.
  sclp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Loop mapping through the divider and output register.
  sclp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/sclp_checker.sv
module sclp_checker
  import sclp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled report stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  // A stalled report keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // An unmapped report carries the raw counter and no iteration count.
  a_raw_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.looping |->
      (out_data_o.loop_position == out_data_o.sample_total) &&
      (out_data_o.loop_iteration == '0))
    else $error("unmapped report is not the raw counter");

  // A mapped position never lies above the counter it came from.
  a_map_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.looping |->
      out_data_o.loop_position <= out_data_o.sample_total)
    else $error("mapped position exceeds sample total");

  // Commands are taken one at a time.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

endmodule

bind sample_clock_loop_position_top sclp_checker u_sclp_checker (.*);
